@@ rtl/dlr_pkg.sv @@
// ----------------------------------------------------------------------------
// dlr_pkg
// shared widths and constants for the dda line rasteriser
// ----------------------------------------------------------------------------
package dlr_pkg;

    // coordinate and fixed-point formats
    localparam int COORD_BITS = 6;
    localparam int FRAC_BITS  = 16;

    // accumulator: coordinate, fraction and one guard bit
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;

    // slope division: (d_minor << FRAC_BITS) / d_major
    localparam int DIVD_BITS  = COORD_BITS + FRAC_BITS;
    localparam int CNT_BITS   = $clog2(DIVD_BITS);

    // step counter holds up to the full coordinate span
    localparam int STEP_BITS  = COORD_BITS + 1;

    // one half in the fraction
    localparam logic [FRAC_BITS-1:0] FRAC_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

endpackage : dlr_pkg

@@ rtl/dlr_div.sv @@
// ----------------------------------------------------------------------------
// dlr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dlr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dlr_pkg::DIVD_BITS-1:0]  i_dividend,
    input  logic [dlr_pkg::COORD_BITS-1:0] i_divisor,
    output logic                          o_done,
    output logic [dlr_pkg::DIVD_BITS-1:0]  o_quotient
);
    import dlr_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [DIVD_BITS-1:0]   r_dvd;      // dividend shifts out, quotient shifts in
    logic [COORD_BITS-1:0]  r_dsr;
    logic [COORD_BITS-1:0]  r_rem;

    logic [COORD_BITS:0]    rem_sh;
    logic [COORD_BITS+1:0]  diff;
    logic                   q_bit;
    logic [COORD_BITS-1:0]  n_rem;

    always_comb begin
        rem_sh = {r_rem, r_dvd[DIVD_BITS-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dsr};
        q_bit  = ~diff[COORD_BITS+1];
        n_rem  = q_bit ? diff[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DIVD_BITS - 1);
                r_dvd  <= i_dividend;
                r_dsr  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[DIVD_BITS-2:0], q_bit};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule : dlr_div

@@ rtl/dda_line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core
// dda line rasteriser: one segment in, one pixel per transfer out
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_start_x/y, i_end_x/y
//  out     | output    | o_out_valid / i_out_ready | o_pixel_x/y, o_last_point
//
//  - a segment takes its input transfer, the serial slope divider, a slope
//    load, then one pixel per output transfer, held while i_out_ready is low;
//    a zero-length segment skips the divider
//  - the restoring divider, one quotient bit a cycle, sets the setup length
//  - o_in_ready is high only while idle; one segment is worked at a time
//  - a stall on i_out_ready holds the current pixel and freezes stepping
//  - synchronous active-low reset returns to idle with no pixel pending
// ----------------------------------------------------------------------------
module dda_line_rasterizer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dlr_pkg::COORD_BITS-1:0] i_start_x,
    input  logic [dlr_pkg::COORD_BITS-1:0] i_start_y,
    input  logic [dlr_pkg::COORD_BITS-1:0] i_end_x,
    input  logic [dlr_pkg::COORD_BITS-1:0] i_end_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dlr_pkg::COORD_BITS-1:0] o_pixel_x,
    output logic [dlr_pkg::COORD_BITS-1:0] o_pixel_y,
    output logic                          o_last_point
);
    import dlr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic                   r_out_valid;

    // per-segment stepping state
    logic [COORD_BITS-1:0]  r_major_pos;
    logic [ACC_BITS-1:0]    r_acc;
    logic [ACC_BITS-1:0]    r_inc;
    logic [STEP_BITS-1:0]   r_steps;
    logic                   r_major_is_x;
    logic                   r_major_neg;
    logic                   r_minor_neg;

    // setup decode of the incoming segment
    logic                   in_xfer;
    logic                   out_xfer;
    logic [COORD_BITS-1:0]  adx;
    logic [COORD_BITS-1:0]  ady;
    logic                   is_x;
    logic [COORD_BITS-1:0]  s_maj;
    logic [COORD_BITS-1:0]  e_maj;
    logic [COORD_BITS-1:0]  s_min;
    logic [COORD_BITS-1:0]  e_min;
    logic [COORD_BITS-1:0]  d_maj;
    logic [COORD_BITS-1:0]  d_min;
    logic                   div_start;

    // divider results
    logic                   div_done;
    logic [DIVD_BITS-1:0]   div_q;
    logic [ACC_BITS-1:0]    inc_mag;

    logic [COORD_BITS-1:0]  minor_coord;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;

    always_comb begin
        adx   = (i_start_x >= i_end_x) ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        ady   = (i_start_y >= i_end_y) ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        // x wins a tie
        is_x  = (adx >= ady);
        s_maj = is_x ? i_start_x : i_start_y;
        e_maj = is_x ? i_end_x   : i_end_y;
        s_min = is_x ? i_start_y : i_start_x;
        e_min = is_x ? i_end_y   : i_end_x;
        d_maj = is_x ? adx : ady;
        d_min = is_x ? ady : adx;
    end

    // zero-length segments skip the divider
    assign div_start = in_xfer && (d_maj != '0);

    dlr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({d_min, {FRAC_BITS{1'b0}}}),
        .i_divisor  (d_maj),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // slope magnitude never exceeds one, so FRAC_BITS+1 bits hold it
    assign inc_mag = ACC_BITS'(div_q[FRAC_BITS:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_major_pos  <= '0;
            r_acc        <= '0;
            r_inc        <= '0;
            r_steps      <= '0;
            r_major_is_x <= 1'b0;
            r_major_neg  <= 1'b0;
            r_minor_neg  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_major_pos  <= s_maj;
                        r_acc        <= ACC_BITS'({s_min, FRAC_HALF});
                        r_steps      <= STEP_BITS'(d_maj);
                        r_major_is_x <= is_x;
                        r_major_neg  <= (e_maj < s_maj);
                        r_minor_neg  <= (e_min < s_min);
                        if (d_maj == '0) begin
                            r_inc       <= '0;
                            r_out_valid <= 1'b1;
                            r_state     <= S_EMIT;
                        end else begin
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        // truncated magnitude, sign applied afterwards
                        r_inc       <= r_minor_neg ? (~inc_mag + 1'b1) : inc_mag;
                        r_out_valid <= 1'b1;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_xfer) begin
                        if (r_steps == '0) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_steps     <= r_steps - 1'b1;
                            r_major_pos <= r_major_neg ? (r_major_pos - 1'b1)
                                                       : (r_major_pos + 1'b1);
                            r_acc       <= r_acc + r_inc;
                        end
                    end
                end
                default: begin
                    r_out_valid <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    // floor of the accumulator gives the minor coordinate
    assign minor_coord  = r_acc[FRAC_BITS +: COORD_BITS];

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_major_is_x ? r_major_pos : minor_coord;
    assign o_pixel_y    = r_major_is_x ? minor_coord : r_major_pos;
    assign o_last_point = (r_steps == '0);

    // input side and output side never both open
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a pixel is pending");

    // last pixel transfer returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_last_point) |=> (o_in_ready && !o_out_valid))
        else $error("not idle after final pixel");

    // a non-final transfer is followed by another pixel
    a_more_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !o_last_point) |=> o_out_valid)
        else $error("pixel stream broke before final pixel");

    // slope magnitude bounded by one
    a_slope_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (div_q[DIVD_BITS-1:FRAC_BITS+1] == '0))
        else $error("slope magnitude above one");

endmodule : dda_line_rasterizer_core

@@ tb/tb_dda_line_rasterizer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer_core
// self-checking bench for the dda line rasteriser core
//
// segments are sent over the input channel; for every accepted transfer the
// bench rasterises the segment itself (same fixed-point dda, 16 fraction
// bits, start + one half, floored) and queues the expected pixels. each
// output transfer is checked field by field against the oldest pixel.
// directed segments cover the corners, both step directions, ties and
// rounding of exact halves; random segments follow, with bursts of idling
// on both channels, one long receiver hold-off and a final stretch at full
// rate.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer_core;

    import dlr_pkg::*;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    // period 12 ns
    localparam int HALF_PERIOD  = 6;
    // slowest run: 432 segments of 64 pixels, every pixel stalled by the longest
    // receiver burst, plus gaps, divider and hold-offs, taken several times over
    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int DRAIN_LIMIT  = 20_000;
    // setup plus divider plus one full-length line
    localparam int TAIL_CYCLES  = 100;
    localparam int MAX_REPORTS  = 100;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    t_coord i_start_x;
    t_coord i_start_y;
    t_coord i_end_x;
    t_coord i_end_y;
    logic   o_out_valid;
    logic   i_out_ready;
    t_coord o_pixel_x;
    t_coord o_pixel_y;
    logic   o_last_point;

    t_pixel expected_pixels[$];
    int     error_count;
    int     cycle_count;
    // set by the tests: no idling on either side while high
    logic   idle_off;
    // receiver hold-off request, counted down by the receiver process
    int     hold_len;
    int     stall_left;

    dda_line_rasterizer_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_point (o_last_point)
    );

    // clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // pixel predictor: walks the whole segment and queues every pixel
    // ------------------------------------------------------------------------
    function automatic void rasterise_segment(input t_coord sx, input t_coord sy,
                                              input t_coord ex, input t_coord ey);
        t_coord               adx;
        t_coord               ady;
        t_coord               maj_pos;
        t_coord               s_min;
        t_coord               e_min;
        t_coord               d_maj;
        t_coord               d_min;
        t_coord               minor;
        logic                 x_major;
        logic                 step_down;
        logic [DIVD_BITS-1:0] slope_mag;
        logic [ACC_BITS-1:0]  acc;
        logic [ACC_BITS-1:0]  inc;
        t_pixel               px;
        adx = (sx >= ex) ? t_coord'(sx - ex) : t_coord'(ex - sx);
        ady = (sy >= ey) ? t_coord'(sy - ey) : t_coord'(ey - sy);
        // x wins a tie
        x_major = (adx >= ady);
        if (x_major) begin
            maj_pos   = sx;
            step_down = (ex < sx);
            s_min     = sy;
            e_min     = ey;
            d_maj     = adx;
            d_min     = ady;
        end else begin
            maj_pos   = sy;
            step_down = (ey < sy);
            s_min     = sx;
            e_min     = ex;
            d_maj     = ady;
            d_min     = adx;
        end
        // magnitude truncated first, sign applied after: rounds toward zero
        if (d_maj != '0)
            slope_mag = (DIVD_BITS'(d_min) << FRAC_BITS) / DIVD_BITS'(d_maj);
        else
            slope_mag = '0;
        if (e_min < s_min)
            inc = ACC_BITS'(0) - ACC_BITS'(slope_mag);
        else
            inc = ACC_BITS'(slope_mag);
        // start + one half, so flooring rounds halves up
        acc = ACC_BITS'({s_min, FRAC_HALF});
        for (int i = 0; i <= int'(d_maj); i++) begin
            minor   = acc[FRAC_BITS +: COORD_BITS];
            px.x    = x_major ? maj_pos : minor;
            px.y    = x_major ? minor : maj_pos;
            px.last = (i == int'(d_maj));
            expected_pixels = {expected_pixels, px};
            maj_pos = step_down ? t_coord'(maj_pos - 1'b1) : t_coord'(maj_pos + 1'b1);
            acc     = acc + inc;
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS)
            $display("mismatch @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // result checker: every output transfer against the oldest pixel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                          o_pixel_x, o_pixel_y, o_last_point));
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_x !== want.x)
                    report_mismatch($sformatf("pixel_x got %0d exp %0d", o_pixel_x, want.x));
                if (o_pixel_y !== want.y)
                    report_mismatch($sformatf("pixel_y got %0d exp %0d", o_pixel_y, want.y));
                if (o_last_point !== want.last)
                    report_mismatch($sformatf("last_point got %0b exp %0b at (%0d,%0d)",
                                              o_last_point, want.last, want.x, want.y));
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stall bursts, plus the long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            hold_len--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 9) == 0) begin
            // random-length stall burst, the current stall included
            stall_left = $urandom_range(1, 16) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // sender: one segment per call, an optional idle burst in front of it
    // ------------------------------------------------------------------------
    task automatic send_segment(input t_coord sx, input t_coord sy,
                                input t_coord ex, input t_coord ey);
        int gap;
        gap = 0;
        if (!idle_off && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x  <= sx;
        i_start_y  <= sy;
        i_end_x    <= ex;
        i_end_y    <= ey;
        // valid held with payload until the transfer
        do @(posedge i_clk); while (!o_in_ready);
        rasterise_segment(sx, sy, ex, ey);
    endtask

    function automatic t_coord near_coord(input t_coord base);
        int v;
        v = int'(base) + $urandom_range(0, 14) - 7;
        if (v < 0)
            v = 0;
        if (v > (1 << COORD_BITS) - 1)
            v = (1 << COORD_BITS) - 1;
        return t_coord'(v);
    endfunction

    function automatic t_coord edge_or_any();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return t_coord'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_segments();
        // zero-length lines at both corners
        send_segment(0, 0, 0, 0);
        send_segment(63, 63, 63, 63);
        // full-span horizontal and vertical, both directions
        send_segment(0, 17, 63, 17);
        send_segment(63, 40, 0, 40);
        send_segment(5, 0, 5, 63);
        send_segment(58, 63, 58, 0);
        // diagonals: equal deltas, x is major
        send_segment(0, 0, 63, 63);
        send_segment(63, 0, 0, 63);
        send_segment(0, 63, 63, 0);
        send_segment(63, 63, 0, 0);
        // shallow and steep, both directions
        send_segment(3, 10, 60, 30);
        send_segment(60, 30, 3, 10);
        send_segment(10, 3, 30, 60);
        send_segment(30, 60, 10, 3);
        // exact halves round up, either direction
        send_segment(0, 0, 2, 1);
        send_segment(2, 1, 0, 0);
        send_segment(0, 0, 1, 2);
        send_segment(1, 2, 0, 0);
        // one-step lines and a slope that does not divide evenly
        send_segment(20, 20, 21, 20);
        send_segment(20, 20, 20, 19);
        send_segment(0, 0, 63, 1);
        send_segment(63, 62, 0, 63);
    endtask

    task automatic test_random_segments(input int count);
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        for (int n = 0; n < count; n++) begin
            // alternate stretches with and without idling
            idle_off = ((n / 40) % 3 == 2);
            sx = t_coord'($urandom());
            sy = t_coord'($urandom());
            case ($urandom_range(0, 3))
                0: begin
                    ex = t_coord'($urandom());
                    ey = t_coord'($urandom());
                end
                1: begin
                    // short lines
                    ex = near_coord(sx);
                    ey = near_coord(sy);
                end
                2: begin
                    // axis aligned or, where the offsets allow, diagonal
                    ex = t_coord'($urandom());
                    case ($urandom_range(0, 2))
                        0:       ey = sy;
                        1:       begin ey = ex; ex = sx; end
                        default: ey = (sy >= sx) ? t_coord'(sy - sx + ex) : t_coord'(ex);
                    endcase
                end
                default: begin
                    sx = edge_or_any();
                    sy = edge_or_any();
                    ex = edge_or_any();
                    ey = edge_or_any();
                end
            endcase
            send_segment(sx, sy, ex, ey);
        end
        idle_off = 1'b0;
    endtask

    task automatic test_output_backpressure(input int count);
        // receiver holds off while the sender keeps offering segments
        hold_len = 400;
        for (int n = 0; n < count; n++)
            send_segment(t_coord'($urandom()), t_coord'($urandom()),
                         t_coord'($urandom()), t_coord'($urandom()));
    endtask

    task automatic test_full_rate(input int count);
        idle_off = 1'b1;
        for (int n = 0; n < count; n++)
            send_segment(t_coord'($urandom()), t_coord'($urandom()),
                         t_coord'($urandom()), t_coord'($urandom()));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int waited;
        error_count = 0;
        cycle_count = 0;
        idle_off    = 1'b0;
        hold_len    = 0;
        stall_left  = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_start_x   = '0;
        i_start_y   = '0;
        i_end_x     = '0;
        i_end_y     = '0;
        i_out_ready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_segments();
        test_random_segments(300);
        test_output_backpressure(10);
        test_full_rate(100);

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain, then let any stray pixel show up
        waited = 0;
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", error_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule : tb_dda_line_rasterizer_core
